// File: rtl/core/rfs_pkg.sv
// ----------------------------------------------------------------------------
// rfs_pkg: shared types and constants of the rounded frame stroke shader
// Register map, control group carried down the pipeline, dither table.
// ----------------------------------------------------------------------------
package rfs_pkg;

  localparam int WC_BITS        = 10;
  localparam int HC_BITS        = 9;
  localparam int COLOR_BITS     = 24;
  localparam int CHAN_BITS      = 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;

  localparam int RADIUS_SCALE   = 3;
  localparam int RADICAND_SHIFT = 6;
  localparam int DIST_SHIFT     = 3;
  localparam int REACH16        = 48;
  localparam int A16_MAX        = 16;
  localparam int A16_BITS       = 5;
  localparam int DITHER_PERIOD  = 40;
  localparam int REM_BITS       = 7;

  localparam logic [WC_BITS-1:0] WIDTH_CELLS_RESET  = WC_BITS'(80);
  localparam logic [HC_BITS-1:0] HEIGHT_CELLS_RESET = HC_BITS'(24);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WIDTH_CELLS   = 3'd0,
    REG_HEIGHT_CELLS  = 3'd1,
    REG_ROUND_CORNERS = 3'd2,
    REG_DITHER_ENABLE = 3'd3,
    REG_STROKE_COLOR  = 3'd4,
    REG_ACCENT_COLOR  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic accent;
    logic blank;
  } ctl_t;

  localparam logic [3:0] BAYER4 [4][4] = '{
    '{4'd0,  4'd8,  4'd2,  4'd10},
    '{4'd12, 4'd4,  4'd14, 4'd6},
    '{4'd3,  4'd11, 4'd1,  4'd9},
    '{4'd15, 4'd7,  4'd13, 4'd5}
  };

endpackage

// File: rtl/core/rounded_frame_stroke_pixel_shader.sv
// ----------------------------------------------------------------------------
// rounded_frame_stroke_pixel_shader: rounded frame stroke with ordered dither
// Shades one pixel per clock: rounded-box distance, coverage, dithered color.
//
// Input: pulse start with pixel_col/pixel_row; a transfer happens when start
// is high and busy is low. busy stays low, so a pixel may enter every cycle.
// Output: red, green, blue, alpha are valid for the one cycle in which done is
// high; the receiver takes every result and cannot stall the pipeline.
// Path from the start transfer to done: rfs_geom, then the rfs_sqrt root
// pipeline of square root width R = 2*ceil((D+4)/2), with D the widest of
// COORD_BITS+1 and the frame extents in bits, then rfs_shade.
// Throughput: one pixel per cycle, set by the two-bit-per-stage root pipeline.
// Configuration: cfg_valid/cfg_ready write channel, index selects the register
// (0 width_cells .. 5 accent_color); cfg_ready is always high. Write only when
// no pixel is in flight.
// Reset (rst, synchronous): clears all valid bits; width_cells 80,
// height_cells 24, other registers 0.
// ----------------------------------------------------------------------------
module rounded_frame_stroke_pixel_shader #(
  parameter int PIXELS_PER_COL = 8,
  parameter int PIXELS_PER_ROW = 16,
  parameter int COORD_BITS     = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [COORD_BITS-1:0]                pixel_col,
  input  logic [COORD_BITS-1:0]                pixel_row,
  output logic                                 done,
  output logic [rfs_pkg::CHAN_BITS-1:0]        red,
  output logic [rfs_pkg::CHAN_BITS-1:0]        green,
  output logic [rfs_pkg::CHAN_BITS-1:0]        blue,
  output logic [rfs_pkg::CHAN_BITS-1:0]        alpha,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rfs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [rfs_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int PW_BITS   = rfs_pkg::WC_BITS + $clog2(PIXELS_PER_COL);
  localparam int PH_BITS   = rfs_pkg::HC_BITS + $clog2(PIXELS_PER_ROW);
  localparam int EXT_BITS  = (PW_BITS > PH_BITS) ? PW_BITS : PH_BITS;
  localparam int DB        = (COORD_BITS + 1 > EXT_BITS) ? COORD_BITS + 1 : EXT_BITS;
  localparam int ROOT_BITS = ((DB + 5) / 2) * 2;
  localparam int RB        = 2 * ROOT_BITS;
  localparam int CELL_SIDE = (PIXELS_PER_COL < PIXELS_PER_ROW) ? PIXELS_PER_COL
                                                               : PIXELS_PER_ROW;
  localparam int RAD_BITS  = $clog2(rfs_pkg::RADIUS_SCALE * CELL_SIDE + 1);
  localparam int SIDE_BITS = DB + 1 + RAD_BITS;

  logic [rfs_pkg::WC_BITS-1:0]    width_cells;
  logic [rfs_pkg::HC_BITS-1:0]    height_cells;
  logic                           round_corners;
  logic                           dither_enable;
  logic [rfs_pkg::COLOR_BITS-1:0] stroke_color;
  logic [rfs_pkg::COLOR_BITS-1:0] accent_color;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cells   <= rfs_pkg::WIDTH_CELLS_RESET;
      height_cells  <= rfs_pkg::HEIGHT_CELLS_RESET;
      round_corners <= 1'b0;
      dither_enable <= 1'b0;
      stroke_color  <= '0;
      accent_color  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rfs_pkg::REG_WIDTH_CELLS:   width_cells   <= cfg_data[rfs_pkg::WC_BITS-1:0];
        rfs_pkg::REG_HEIGHT_CELLS:  height_cells  <= cfg_data[rfs_pkg::HC_BITS-1:0];
        rfs_pkg::REG_ROUND_CORNERS: round_corners <= cfg_data[0];
        rfs_pkg::REG_DITHER_ENABLE: dither_enable <= cfg_data[0];
        rfs_pkg::REG_STROKE_COLOR:  stroke_color  <= cfg_data[rfs_pkg::COLOR_BITS-1:0];
        rfs_pkg::REG_ACCENT_COLOR:  accent_color  <= cfg_data[rfs_pkg::COLOR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  rfs_pkg::ctl_t        geo_ctl;
  logic [RB-1:0]        geo_radicand;
  logic signed [DB:0]   geo_inside;
  logic [RAD_BITS-1:0]  geo_rad2;
  logic [SIDE_BITS-1:0] geo_side;

  rfs_geom #(
    .PIXELS_PER_COL (PIXELS_PER_COL),
    .PIXELS_PER_ROW (PIXELS_PER_ROW),
    .COORD_BITS     (COORD_BITS),
    .DB             (DB),
    .RB             (RB),
    .RAD_BITS       (RAD_BITS)
  ) u_geom (
    .clk           (clk),
    .rst           (rst),
    .start         (start && !busy),
    .pixel_col     (pixel_col),
    .pixel_row     (pixel_row),
    .width_cells   (width_cells),
    .height_cells  (height_cells),
    .round_corners (round_corners),
    .dither_enable (dither_enable),
    .ctl           (geo_ctl),
    .radicand      (geo_radicand),
    .inner         (geo_inside),
    .rad2          (geo_rad2)
  );

  assign geo_side = {geo_inside, geo_rad2};

  rfs_pkg::ctl_t        sq_ctl;
  logic [ROOT_BITS-1:0] sq_root;
  logic [SIDE_BITS-1:0] sq_side;
  logic signed [DB:0]   sq_inside;
  logic [RAD_BITS-1:0]  sq_rad2;

  rfs_sqrt #(
    .ROOT_BITS (ROOT_BITS),
    .SIDE_BITS (SIDE_BITS)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (geo_ctl),
    .radicand (geo_radicand),
    .side_in  (geo_side),
    .ctl_out  (sq_ctl),
    .root     (sq_root),
    .side_out (sq_side)
  );

  assign sq_inside = $signed(sq_side[SIDE_BITS-1 -: DB+1]);
  assign sq_rad2   = sq_side[RAD_BITS-1:0];

  rfs_shade #(
    .ROOT_BITS (ROOT_BITS),
    .DB        (DB),
    .RAD_BITS  (RAD_BITS)
  ) u_shade (
    .clk          (clk),
    .rst          (rst),
    .ctl          (sq_ctl),
    .root         (sq_root),
    .inner        (sq_inside),
    .rad2         (sq_rad2),
    .stroke_color (stroke_color),
    .accent_color (accent_color),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .done         (done)
  );

endmodule

// File: rtl/core/rfs_geom.sv
// ----------------------------------------------------------------------------
// rfs_geom: frame geometry and dither front end
// Five stages: box extents and radius, edge offsets, excess and inside term,
// squares, radicand; the dither decision runs alongside.
// ----------------------------------------------------------------------------
module rfs_geom #(
  parameter int PIXELS_PER_COL = 8,
  parameter int PIXELS_PER_ROW = 16,
  parameter int COORD_BITS     = 12,
  parameter int DB             = 13,
  parameter int RB             = 36,
  parameter int RAD_BITS       = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [COORD_BITS-1:0]              pixel_col,
  input  logic [COORD_BITS-1:0]              pixel_row,
  input  logic [rfs_pkg::WC_BITS-1:0]        width_cells,
  input  logic [rfs_pkg::HC_BITS-1:0]        height_cells,
  input  logic                               round_corners,
  input  logic                               dither_enable,
  output rfs_pkg::ctl_t                      ctl,
  output logic [RB-1:0]                      radicand,
  output logic signed [DB:0]                 inner,
  output logic [RAD_BITS-1:0]                rad2
);

  localparam int PW_BITS    = rfs_pkg::WC_BITS + $clog2(PIXELS_PER_COL);
  localparam int PH_BITS    = rfs_pkg::HC_BITS + $clog2(PIXELS_PER_ROW);
  localparam int EXT_BITS   = (PW_BITS > PH_BITS) ? PW_BITS : PH_BITS;
  localparam int SW         = DB + 1;
  localparam int SQ         = 2 * DB;
  localparam int SB         = COORD_BITS + 1;
  localparam int RK         = SB + 6;
  localparam int RECIP      = (2 ** RK) / rfs_pkg::DITHER_PERIOD;
  localparam int PRODW      = 2 * SB + 1;
  localparam int CELL_SIDE  = (PIXELS_PER_COL < PIXELS_PER_ROW) ? PIXELS_PER_COL
                                                                : PIXELS_PER_ROW;
  localparam int RAD_MAX    = rfs_pkg::RADIUS_SCALE * CELL_SIDE;

  // stage 1
  logic [PW_BITS-1:0]    pw;
  logic [PH_BITS-1:0]    ph;
  logic [EXT_BITS-1:0]   ext_min;
  logic [RAD_BITS-1:0]   rad2_next;
  logic                  s1_valid;
  logic                  s1_blank;
  logic [COORD_BITS-1:0] s1_x;
  logic [COORD_BITS-1:0] s1_y;
  logic [PW_BITS-1:0]    s1_ext_w;
  logic [PH_BITS-1:0]    s1_ext_h;
  logic [RAD_BITS-1:0]   s1_rad2;

  assign pw = PW_BITS'(width_cells) * PW_BITS'(PIXELS_PER_COL);
  assign ph = PH_BITS'(height_cells) * PH_BITS'(PIXELS_PER_ROW);

  always_comb begin
    logic [EXT_BITS-1:0] ew;
    logic [EXT_BITS-1:0] eh;
    ew = EXT_BITS'(pw - PW_BITS'(1));
    eh = EXT_BITS'(ph - PH_BITS'(1));
    ext_min = (ew < eh) ? ew : eh;
    if (!round_corners) begin
      rad2_next = '0;
    end else if (ext_min >= EXT_BITS'(RAD_MAX + 2)) begin
      rad2_next = RAD_BITS'(RAD_MAX);
    end else if (ext_min > EXT_BITS'(2)) begin
      rad2_next = RAD_BITS'(ext_min - EXT_BITS'(2));
    end else begin
      rad2_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    s1_blank <= (width_cells == '0) || (height_cells == '0);
    s1_x     <= pixel_col;
    s1_y     <= pixel_row;
    s1_ext_w <= pw - PW_BITS'(1);
    s1_ext_h <= ph - PH_BITS'(1);
    s1_rad2  <= rad2_next;
  end

  // stage 2
  logic signed [SW-1:0] dx;
  logic signed [SW-1:0] dy;
  logic                 s2_valid;
  logic                 s2_blank;
  logic [DB-1:0]        s2_ax;
  logic [DB-1:0]        s2_ay;
  logic [DB-1:0]        s2_bw;
  logic [DB-1:0]        s2_bh;
  logic [RAD_BITS-1:0]  s2_rad2;
  logic [SB-1:0]        s2_sum;
  logic [3:0]           s2_bay;

  assign dx = $signed(SW'({s1_x, 1'b0})) - $signed(SW'(s1_ext_w));
  assign dy = $signed(SW'({s1_y, 1'b0})) - $signed(SW'(s1_ext_h));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_blank <= s1_blank;
    s2_ax    <= DB'((dx < 0) ? -dx : dx);
    s2_ay    <= DB'((dy < 0) ? -dy : dy);
    s2_bw    <= DB'(s1_ext_w) - DB'(s1_rad2);
    s2_bh    <= DB'(s1_ext_h) - DB'(s1_rad2);
    s2_rad2  <= s1_rad2;
    s2_sum   <= SB'(s1_x) + SB'(s1_y);
    s2_bay   <= rfs_pkg::BAYER4[s1_x[1:0]][s1_y[1:0]];
  end

  // stage 3
  logic signed [SW-1:0] qx;
  logic signed [SW-1:0] qy;
  logic signed [SW-1:0] qmax;
  logic [PRODW-1:0]     prod;
  logic                 s3_valid;
  logic                 s3_blank;
  logic [DB-1:0]        s3_ox;
  logic [DB-1:0]        s3_oy;
  logic signed [SW-1:0] s3_inside;
  logic [RAD_BITS-1:0]  s3_rad2;
  logic [SB-1:0]        s3_sum;
  logic [SB-1:0]        s3_q;
  logic [3:0]           s3_bay;

  assign qx   = $signed({1'b0, s2_ax}) - $signed({1'b0, s2_bw});
  assign qy   = $signed({1'b0, s2_ay}) - $signed({1'b0, s2_bh});
  assign qmax = (qx > qy) ? qx : qy;
  assign prod = PRODW'(s2_sum) * PRODW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_blank  <= s2_blank;
    s3_ox     <= (qx > 0) ? DB'(qx) : '0;
    s3_oy     <= (qy > 0) ? DB'(qy) : '0;
    s3_inside <= (qmax > 0) ? '0 : qmax;
    s3_rad2   <= s2_rad2;
    s3_sum    <= s2_sum;
    s3_q      <= SB'(prod >> RK);
    s3_bay    <= s2_bay;
  end

  // stage 4
  logic                          s4_valid;
  logic                          s4_blank;
  logic [SQ-1:0]                 s4_sqx;
  logic [SQ-1:0]                 s4_sqy;
  logic signed [SW-1:0]          s4_inside;
  logic [RAD_BITS-1:0]           s4_rad2;
  logic [rfs_pkg::REM_BITS-1:0]  s4_rem;
  logic [3:0]                    s4_bay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_blank  <= s3_blank;
    s4_sqx    <= SQ'(s3_ox) * SQ'(s3_ox);
    s4_sqy    <= SQ'(s3_oy) * SQ'(s3_oy);
    s4_inside <= s3_inside;
    s4_rad2   <= s3_rad2;
    s4_rem    <= rfs_pkg::REM_BITS'(s3_sum - s3_q * SB'(rfs_pkg::DITHER_PERIOD));
    s4_bay    <= s3_bay;
  end

  // stage 5
  logic [5:0] phase;
  logic [7:0] lhs;
  logic [7:0] odd;
  logic [7:0] thr;

  assign phase = (s4_rem >= rfs_pkg::REM_BITS'(rfs_pkg::DITHER_PERIOD))
               ? 6'(s4_rem - rfs_pkg::REM_BITS'(rfs_pkg::DITHER_PERIOD))
               : 6'(s4_rem);
  assign lhs   = {phase, 2'b00};
  assign odd   = {3'b000, s4_bay, 1'b1};
  assign thr   = (odd << 2) + odd;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid  <= s4_valid;
      ctl.accent <= dither_enable && (lhs > thr);
      ctl.blank  <= s4_blank;
    end
    radicand <= (RB'(s4_sqx) + RB'(s4_sqy)) << rfs_pkg::RADICAND_SHIFT;
    inner    <= s4_inside;
    rad2     <= s4_rad2;
  end

endmodule

// File: rtl/core/rfs_sqrt.sv
// ----------------------------------------------------------------------------
// rfs_sqrt: pipelined integer square root
// Restoring digit recurrence, two result bits per stage, side data carried.
// ----------------------------------------------------------------------------
module rfs_sqrt #(
  parameter int ROOT_BITS = 18,
  parameter int SIDE_BITS = 22
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rfs_pkg::ctl_t            ctl_in,
  input  logic [2*ROOT_BITS-1:0]   radicand,
  input  logic [SIDE_BITS-1:0]     side_in,
  output rfs_pkg::ctl_t            ctl_out,
  output logic [ROOT_BITS-1:0]     root,
  output logic [SIDE_BITS-1:0]     side_out
);

  localparam int RB     = 2 * ROOT_BITS;
  localparam int RW     = ROOT_BITS + 3;
  localparam int STAGES = ROOT_BITS / 2;

  rfs_pkg::ctl_t        ctl_q  [STAGES];
  logic [RW-1:0]        rem_q  [STAGES];
  logic [ROOT_BITS-1:0] root_q [STAGES];
  logic [RB-1:0]        rad_q  [STAGES];
  logic [SIDE_BITS-1:0] side_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    rfs_pkg::ctl_t        ctl_in_s;
    logic [RW-1:0]        rem_in;
    logic [ROOT_BITS-1:0] root_in;
    logic [RB-1:0]        rad_in;
    logic [SIDE_BITS-1:0] side_in_s;
    logic [RW-1:0]        rem_next;
    logic [ROOT_BITS-1:0] root_next;
    logic [RB-1:0]        rad_next;

    if (i == 0) begin : g_first
      assign ctl_in_s  = ctl_in;
      assign rem_in    = '0;
      assign root_in   = '0;
      assign rad_in    = radicand;
      assign side_in_s = side_in;
    end else begin : g_rest
      assign ctl_in_s  = ctl_q[i-1];
      assign rem_in    = rem_q[i-1];
      assign root_in   = root_q[i-1];
      assign rad_in    = rad_q[i-1];
      assign side_in_s = side_q[i-1];
    end

    always_comb begin
      logic [RW-1:0] acc;
      logic [RW-1:0] trial;
      rem_next  = rem_in;
      root_next = root_in;
      rad_next  = rad_in;
      for (int k = 0; k < 2; k++) begin
        acc   = {rem_next[RW-3:0], rad_next[RB-1 -: 2]};
        trial = RW'({root_next, 2'b01});
        if (acc >= trial) begin
          rem_next  = acc - trial;
          root_next = {root_next[ROOT_BITS-2:0], 1'b1};
        end else begin
          rem_next  = acc;
          root_next = {root_next[ROOT_BITS-2:0], 1'b0};
        end
        rad_next = {rad_next[RB-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[i] <= '0;
      end else begin
        ctl_q[i] <= ctl_in_s;
      end
      rem_q[i]  <= rem_next;
      root_q[i] <= root_next;
      rad_q[i]  <= rad_next;
      side_q[i] <= side_in_s;
    end
  end

  assign ctl_out  = ctl_q[STAGES-1];
  assign root     = root_q[STAGES-1];
  assign side_out = side_q[STAGES-1];

endmodule

// File: rtl/core/rfs_shade.sv
// ----------------------------------------------------------------------------
// rfs_shade: distance to coverage and color
// Two stages: signed distance and clamped coverage, then alpha and color.
// ----------------------------------------------------------------------------
module rfs_shade #(
  parameter int ROOT_BITS = 18,
  parameter int DB        = 13,
  parameter int RAD_BITS  = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rfs_pkg::ctl_t                       ctl,
  input  logic [ROOT_BITS-1:0]                root,
  input  logic signed [DB:0]                  inner,
  input  logic [RAD_BITS-1:0]                 rad2,
  input  logic [rfs_pkg::COLOR_BITS-1:0]      stroke_color,
  input  logic [rfs_pkg::COLOR_BITS-1:0]      accent_color,
  output logic [rfs_pkg::CHAN_BITS-1:0]       red,
  output logic [rfs_pkg::CHAN_BITS-1:0]       green,
  output logic [rfs_pkg::CHAN_BITS-1:0]       blue,
  output logic [rfs_pkg::CHAN_BITS-1:0]       alpha,
  output logic                                done
);

  localparam int DW = ROOT_BITS + 3;

  logic signed [DW-1:0]          ins_ext;
  logic signed [DW-1:0]          sdist;
  logic [DW-1:0]                 mag;
  logic [rfs_pkg::A16_BITS-1:0]  a16_next;
  rfs_pkg::ctl_t                 ctl_a;
  logic [rfs_pkg::A16_BITS-1:0]  a16;

  assign ins_ext = DW'(inner);
  assign sdist   = $signed({3'b000, root}) + (ins_ext <<< rfs_pkg::DIST_SHIFT)
                 - $signed(DW'({rad2, 3'b000}));
  assign mag     = (sdist < 0) ? DW'(-sdist) : DW'(sdist);

  always_comb begin
    if (mag >= DW'(rfs_pkg::REACH16)) begin
      a16_next = '0;
    end else if (mag <= DW'(rfs_pkg::REACH16 - rfs_pkg::A16_MAX)) begin
      a16_next = rfs_pkg::A16_BITS'(rfs_pkg::A16_MAX);
    end else begin
      a16_next = rfs_pkg::A16_BITS'(DW'(rfs_pkg::REACH16) - mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else begin
      ctl_a <= ctl;
    end
    a16 <= a16_next;
  end

  logic [12:0]                    scaled;
  logic                           covered;
  logic [rfs_pkg::COLOR_BITS-1:0] color;

  assign scaled  = {a16, 8'b0} - 13'(a16);
  assign covered = (a16 != '0) && !ctl_a.blank;
  assign color   = ctl_a.accent ? accent_color : stroke_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_a.valid;
    end
    red   <= covered ? color[23:16] : '0;
    green <= covered ? color[15:8] : '0;
    blue  <= covered ? color[7:0] : '0;
    alpha <= covered ? rfs_pkg::CHAN_BITS'(scaled >> 4) : '0;
  end

endmodule
